// ----- src/rgb565_blitter_fill_copy_blend_core_assert.svh -----
// Assertion macros for the blitter core
`ifndef RGB565_BLITTER_FILL_COPY_BLEND_CORE_ASSERT_SVH
`define RGB565_BLITTER_FILL_COPY_BLEND_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blitter check failed");
`define BLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blitter check failed");
`else
`define BLT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BLT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/blt_pkg.sv -----
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types, codes and the per-channel blend function.
// ----------------------------------------------------------------------------
package blt_pkg;
	localparam int AddrW = 16;
	localparam int DimW  = 13;
	localparam int MaxDim = 4096;

	typedef enum logic [2:0] {
		FN_FILL = 3'd0, FN_COPY = 3'd1, FN_BLEND = 3'd2,
		FN_PWRITE = 3'd3, FN_PREAD = 3'd4
	} func_t;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_IGNORE = 2'd2;

	localparam logic [2:0] REG_DST_BASE = 3'd0;
	localparam logic [2:0] REG_DST_W    = 3'd1;
	localparam logic [2:0] REG_DST_H    = 3'd2;
	localparam logic [2:0] REG_SRC_BASE = 3'd3;
	localparam logic [2:0] REG_SRC_W    = 3'd4;
	localparam logic [2:0] REG_SRC_H    = 3'd5;

	typedef struct packed {
		logic             we;
		logic [AddrW-1:0] waddr;
		logic [15:0]      wdata;
		logic             re;
		logic [AddrW-1:0] raddr;
	} mem_req_t;

	// one channel: (s*a + d*(255-a)) / 255 via reciprocal and one correction
	function automatic logic [5:0] mix_ch(input logic [5:0] s, input logic [5:0] d,
			input logic [7:0] a);
		logic [14:0] sum;
		logic [23:0] prod;
		logic [14:0] q;
		logic [14:0] rem;
		sum  = 15'(s) * 15'(a) + 15'(d) * (15'd255 - 15'(a));
		prod = 24'(sum) * 24'd257;
		q    = 15'(prod >> 16);
		rem  = sum - 15'(q * 15'd255);
		if (rem >= 15'd255) q = q + 15'd1;
		return q[5:0];
	endfunction

	function automatic logic [15:0] mix(input logic [15:0] s, input logic [15:0] d,
			input logic [7:0] a);
		logic [5:0] r, g, b;
		r = mix_ch({1'b0, s[15:11]}, {1'b0, d[15:11]}, a);
		g = mix_ch(s[10:5], d[10:5], a);
		b = mix_ch({1'b0, s[4:0]}, {1'b0, d[4:0]}, a);
		return {r[4:0], g, b[4:0]};
	endfunction
endpackage

// ----- src/rgb565_blitter_fill_copy_blend_core.sv -----
// Pixel write, reject and ignore pass CLIP then RESP; pixel read adds PRD;
// per pixel: fill WR; copy SRD, WR; blend SRD, DRD, WR (area after clipping).
// One command at a time; busy stays high until the result strobe. Reset clears
// control, sets bases to 0 and sizes to 256; memory is undefined until written.
// The result is shown for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// rgb565_blitter_fill_copy_blend_core
// Command sequencer walking rectangles over the pixel memory.
// ----------------------------------------------------------------------------
`include "rgb565_blitter_fill_copy_blend_core_assert.svh"
module rgb565_blitter_fill_copy_blend_core import blt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [11:0] dst_x,
	input  logic [11:0] dst_y,
	input  logic [11:0] rect_width,
	input  logic [11:0] rect_height,
	input  logic [11:0] src_x,
	input  logic [11:0] src_y,
	input  logic [15:0] pixel_value,
	input  logic [7:0]  alpha,
	input  logic [15:0] pixel_address,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] read_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	typedef enum logic [2:0] {S_IDLE, S_CLIP, S_SRD, S_DRD, S_WR, S_PRD, S_RESP} state_t;

	logic [AddrW-1:0] dst_base, src_base;
	logic [DimW-1:0] dst_width, dst_height, src_width, src_height;
	logic [DimW-1:0] dw, dh, sw, sh;
	mem_req_t req;
	logic [15:0] rdata;

	state_t state_q;
	logic done_q;
	logic [1:0] status_q;
	logic [15:0] read_data_q;
	logic [2:0] func_q;
	logic [11:0] dx_q, dy_q, sx_q, sy_q, w_q, h_q, col_q, row_q;
	logic [15:0] pv_q, pa_q, src_pix_q;
	logic [7:0] alpha_q;
	logic [AddrW-1:0] drow_q, srow_q;

	assign pready = 1'b1;

	blt_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.dst_base, .dst_width, .dst_height, .src_base, .src_width, .src_height
	);
	blt_mem u_mem (.clk, .req, .rdata);

	// clamp dimensions
	assign dw = (dst_width  > DimW'(MaxDim)) ? DimW'(MaxDim) : dst_width;
	assign dh = (dst_height > DimW'(MaxDim)) ? DimW'(MaxDim) : dst_height;
	assign sw = (src_width  > DimW'(MaxDim)) ? DimW'(MaxDim) : src_width;
	assign sh = (src_height > DimW'(MaxDim)) ? DimW'(MaxDim) : src_height;

	// clip arithmetic
	logic [DimW-1:0] dw_rem, dh_rem, sw_rem, sh_rem, cw, ch;
	logic reject;
	assign dw_rem = dw - DimW'(dx_q);
	assign dh_rem = dh - DimW'(dy_q);
	assign sw_rem = sw - DimW'(sx_q);
	assign sh_rem = sh - DimW'(sy_q);
	assign reject = ({1'b0, dx_q} >= dw) || ({1'b0, dy_q} >= dh) ||
		(func_q != FN_FILL && (({1'b0, sx_q} >= sw) || ({1'b0, sy_q} >= sh)));
	always_comb begin
		cw = DimW'(w_q);
		ch = DimW'(h_q);
		if (cw > dw_rem) cw = dw_rem;
		if (ch > dh_rem) ch = dh_rem;
		if (func_q != FN_FILL) begin
			if (cw > sw_rem) cw = sw_rem;
			if (ch > sh_rem) ch = sh_rem;
		end
	end

	// current addresses (row base held, column added)
	logic [AddrW-1:0] daddr, saddr;
	assign daddr = drow_q + AddrW'(dx_q) + AddrW'(col_q);
	assign saddr = srow_q + AddrW'(sx_q) + AddrW'(col_q);

	logic last_col, last_row;
	assign last_col = (col_q + 12'd1 == w_q);
	assign last_row = (row_q + 12'd1 == h_q);

	// memory requests
	always_comb begin
		req = '0;
		case (state_q)
			S_SRD: begin req.re = 1'b1; req.raddr = saddr; end
			S_DRD: begin req.re = 1'b1; req.raddr = daddr; end
			S_PRD: begin req.re = 1'b1; req.raddr = pa_q; end
			S_CLIP: begin
				req.we = (func_q == FN_PWRITE);
				req.waddr = pa_q;
				req.wdata = pv_q;
			end
			S_WR: begin
				req.we = 1'b1;
				req.waddr = daddr;
				case (func_q)
					FN_FILL: req.wdata = pv_q;
					FN_COPY: req.wdata = rdata;
					default: req.wdata = mix(src_pix_q, rdata, alpha_q);
				endcase
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			status_q <= ST_DONE;
			read_data_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					func_q <= func; dx_q <= dst_x; dy_q <= dst_y;
					sx_q <= src_x; sy_q <= src_y; w_q <= rect_width;
					h_q <= rect_height; pv_q <= pixel_value; alpha_q <= alpha;
					pa_q <= pixel_address;
					state_q <= S_CLIP;
				end
				S_CLIP: begin
					status_q <= ST_DONE;
					read_data_q <= '0;
					col_q <= '0; row_q <= '0;
					drow_q <= dst_base + AddrW'(32'(dy_q) * 32'(dw));
					srow_q <= src_base + AddrW'(32'(sy_q) * 32'(sw));
					w_q <= cw[11:0];
					h_q <= ch[11:0];
					if (func_q == FN_PWRITE) state_q <= S_RESP;
					else if (func_q == FN_PREAD) state_q <= S_PRD;
					else if (func_q > FN_PREAD) begin
						status_q <= ST_IGNORE; state_q <= S_RESP;
					end else if (reject) begin
						status_q <= ST_REJECT; state_q <= S_RESP;
					end else if (cw == '0 || ch == '0) state_q <= S_RESP;
					else if (func_q == FN_FILL) state_q <= S_WR;
					else state_q <= S_SRD;
				end
				S_PRD: state_q <= S_RESP;
				S_SRD: state_q <= (func_q == FN_BLEND) ? S_DRD : S_WR;
				S_DRD: begin src_pix_q <= rdata; state_q <= S_WR; end
				S_WR: begin
					if (last_col) begin
						col_q <= '0;
						drow_q <= drow_q + AddrW'(dw);
						srow_q <= srow_q + AddrW'(sw);
						row_q <= row_q + 12'd1;
						if (last_row) state_q <= S_RESP;
						else state_q <= (func_q == FN_FILL) ? S_WR : S_SRD;
					end else begin
						col_q <= col_q + 12'd1;
						state_q <= (func_q == FN_FILL) ? S_WR : S_SRD;
					end
				end
				S_RESP: begin
					if (func_q == FN_PREAD) read_data_q <= rdata;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign read_data = read_data_q;

	`BLT_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`BLT_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`BLT_ASSERT_IMP(a_rd_zero, clk, arst_n, done && status != ST_DONE, read_data == '0)
endmodule

// ----- src/blt_regs.sv -----
// ----------------------------------------------------------------------------
// blt_regs
// APB register file holding the surface descriptors.
// ----------------------------------------------------------------------------
module blt_regs import blt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic [AddrW-1:0]  dst_base,
	output logic [DimW-1:0]   dst_width,
	output logic [DimW-1:0]   dst_height,
	output logic [AddrW-1:0]  src_base,
	output logic [DimW-1:0]   src_width,
	output logic [DimW-1:0]   src_height
);
	logic [2:0] idx;
	logic [AddrW-1:0] dst_base_q, src_base_q;
	logic [DimW-1:0] dst_width_q, dst_height_q, src_width_q, src_height_q;
	assign idx = paddr[4:2];

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_base_q <= '0; dst_width_q <= DimW'(256); dst_height_q <= DimW'(256);
			src_base_q <= '0; src_width_q <= DimW'(256); src_height_q <= DimW'(256);
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_DST_BASE: dst_base_q   <= pwdata[AddrW-1:0];
				REG_DST_W:    dst_width_q  <= pwdata[DimW-1:0];
				REG_DST_H:    dst_height_q <= pwdata[DimW-1:0];
				REG_SRC_BASE: src_base_q   <= pwdata[AddrW-1:0];
				REG_SRC_W:    src_width_q  <= pwdata[DimW-1:0];
				REG_SRC_H:    src_height_q <= pwdata[DimW-1:0];
				default: ;
			endcase
		end
	end

	assign dst_base   = dst_base_q;
	assign dst_width  = dst_width_q;
	assign dst_height = dst_height_q;
	assign src_base   = src_base_q;
	assign src_width  = src_width_q;
	assign src_height = src_height_q;

	// read back
	always_comb begin
		case (idx)
			REG_DST_BASE: prdata = 32'(dst_base_q);
			REG_DST_W:    prdata = 32'(dst_width_q);
			REG_DST_H:    prdata = 32'(dst_height_q);
			REG_SRC_BASE: prdata = 32'(src_base_q);
			REG_SRC_W:    prdata = 32'(src_width_q);
			REG_SRC_H:    prdata = 32'(src_height_q);
			default:      prdata = '0;
		endcase
	end
endmodule

// ----- src/blt_mem.sv -----
// ----------------------------------------------------------------------------
// blt_mem
// Pixel memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module blt_mem import blt_pkg::*; (
	input  logic        clk,
	input  mem_req_t    req,
	output logic [15:0] rdata
);
	logic [15:0] mem [2**AddrW];

	// write and registered read
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		if (req.re) rdata <= mem[req.raddr];
	end
endmodule
